// ===== hw/rtl/unfd_pkg.sv =====
// Shared types and constants for the serial frame deframer.
`timescale 1ns / 1ps

package unfd_pkg;

  // Result kinds
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_LINK    = 3'd1;
  localparam logic [2:0] KIND_MAC     = 3'd2;
  localparam logic [2:0] KIND_UNKNOWN = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  // Message type codes
  localparam logic [7:0] TYPE_MAC    = 8'd0;
  localparam logic [7:0] TYPE_LINK   = 8'd1;
  localparam logic [7:0] TYPE_PACKET = 8'd3;

  // Sync pattern U, N, U
  localparam logic [7:0] SYNC_U = 8'h55;
  localparam logic [7:0] SYNC_N = 8'h4E;
  localparam logic [1:0] SYNC_LAST = 2'd2;

  localparam logic [15:0] MAX_LEN_RESET = 16'd1536;

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_TYPE    = 6'b000010,
    PH_LINK    = 6'b000100,
    PH_MAC     = 6'b001000,
    PH_PLEN    = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] mac_index;
    logic       last;
  } res_t;

  // Expected byte at each position of the sync pattern
  function automatic logic [7:0] sync_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd1:    val = SYNC_N;
      default: val = SYNC_U;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/uart_nic_frame_deframer.sv =====
// Top level of the serial-link frame deframer (sync hunt, type decode, payload out).
// Pipeline: a beat accepted is held in the input register, then its result beat (if any)
//   is held in the result register, from which it is taken.
// Throughput: one input beat per cycle; the input register advances whenever the
//   result register is empty or being drained in the same cycle.
// Reset (rst, synchronous): parser back to sync hunt, all counters zero, both
//   stages empty, max_packet_len back to 1536.
`timescale 1ns / 1ps

module uart_nic_frame_deframer #(
  parameter int LENGTH_FIELD_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [7:0]  mac_index,
  output logic        last_of_packet,
  // max_packet_len register
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic           stage_valid;
  logic [7:0]     stage_byte;
  logic           advance;
  logic           free;
  logic           res_valid;
  unfd_pkg::res_t res;
  unfd_pkg::res_t out_res;
  logic [15:0]    max_packet_len;

  // Largest accepted payload; the user must write it only while the datapath is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_len <= unfd_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_packet_len <= cfg_wr_data;
    end
  end

  // A held byte is processed once the result register can take whatever it
  // produces; bytes that produce no result still wait, keeping order simple.
  assign advance = stage_valid && free;

  unfd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .stage_valid(stage_valid),
    .stage_byte (stage_byte)
  );

  // Parser state steps once per processed byte.
  unfd_core #(
    .LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .stage_byte    (stage_byte),
    .max_packet_len(max_packet_len),
    .res_valid     (res_valid),
    .res           (res)
  );

  unfd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .free     (free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_byte       = out_res.data;
  assign mac_index      = out_res.mac_index;
  assign last_of_packet = out_res.last;

  // Drop flag always closes a packet.
  a_drop_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == unfd_pkg::KIND_DROP |-> last_of_packet)
    else $error("drop beat without last flag");

  // Only MAC beats carry a position.
  a_mac_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != unfd_pkg::KIND_MAC |-> mac_index == 8'd0)
    else $error("nonzero mac_index on non-MAC beat");

  // Back-pressure on the input only comes from a held byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> in_ready)
    else $error("input stalled with empty stage");

  // Both stages come out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !stage_valid)
    else $error("stage valid after reset");

endmodule

// ===== hw/rtl/unfd_in_stage.sv =====
// Input register stage holding one received byte.
`timescale 1ns / 1ps

module unfd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       stage_valid,
  output logic [7:0] stage_byte
);

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= rx_byte;
    end
  end

endmodule

// ===== hw/rtl/unfd_core.sv =====
// Frame parser state and per-byte result logic.
`timescale 1ns / 1ps

module unfd_core #(
  parameter int LENGTH_FIELD_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        stage_byte,
  input  logic [15:0]       max_packet_len,
  output logic              res_valid,
  output unfd_pkg::res_t    res
);

  localparam int LEN_W = 8 * LENGTH_FIELD_BYTES;
  localparam int LBR_W = $clog2(LENGTH_FIELD_BYTES + 1);
  localparam int CMP_W = (LEN_W > 16) ? LEN_W : 16;

  unfd_pkg::phase_t phase, phase_next;
  logic [1:0]       sync_matched, sync_matched_next;
  logic [7:0]       mac_length, mac_length_next;
  logic [7:0]       mac_count, mac_count_next;
  logic [LBR_W-1:0] length_bytes_read, length_bytes_read_next;
  logic [LEN_W-1:0] payload_length, payload_length_next;
  logic [LEN_W-1:0] payload_count, payload_count_next;

  logic [LEN_W-1:0] len_asm;
  logic [LEN_W-1:0] count_inc;
  logic             oversize;
  logic             at_last;

  assign count_inc = payload_count + LEN_W'(1);
  assign at_last   = (count_inc == payload_length);
  assign oversize  = CMP_W'(payload_length) > CMP_W'(max_packet_len);

  always_comb begin
    len_asm = payload_length;
    for (int i = 0; i < LENGTH_FIELD_BYTES; i++) begin
      if (length_bytes_read == LBR_W'(i)) begin
        len_asm[8*i +: 8] = stage_byte;
      end
    end
  end

  always_comb begin
    phase_next             = phase;
    sync_matched_next      = sync_matched;
    mac_length_next        = mac_length;
    mac_count_next         = mac_count;
    length_bytes_read_next = length_bytes_read;
    payload_length_next    = payload_length;
    payload_count_next     = payload_count;
    res_valid              = 1'b0;
    res                    = '{kind: unfd_pkg::KIND_PAYLOAD, data: 8'h00,
                               mac_index: 8'h00, last: 1'b0};
    case (phase)
      unfd_pkg::PH_HUNT: begin
        if (stage_byte == unfd_pkg::sync_byte(sync_matched)) begin
          if (sync_matched == unfd_pkg::SYNC_LAST) begin
            sync_matched_next = 2'd0;
            phase_next        = unfd_pkg::PH_TYPE;
          end else begin
            sync_matched_next = sync_matched + 2'd1;
          end
        end else begin
          sync_matched_next = 2'd0;
        end
      end
      unfd_pkg::PH_TYPE: begin
        if (stage_byte == unfd_pkg::TYPE_MAC) begin
          phase_next = unfd_pkg::PH_MAC;
        end else if (stage_byte == unfd_pkg::TYPE_LINK) begin
          phase_next = unfd_pkg::PH_LINK;
        end else if (stage_byte == unfd_pkg::TYPE_PACKET) begin
          phase_next             = unfd_pkg::PH_PLEN;
          length_bytes_read_next = '0;
          payload_length_next    = '0;
          payload_count_next     = '0;
        end else begin
          res_valid = 1'b1;
          res.kind  = unfd_pkg::KIND_UNKNOWN;
          res.data  = stage_byte;
        end
      end
      unfd_pkg::PH_LINK: begin
        phase_next = unfd_pkg::PH_HUNT;
        res_valid  = 1'b1;
        res.kind   = unfd_pkg::KIND_LINK;
        res.data   = {7'd0, (stage_byte != 8'd0)};
      end
      unfd_pkg::PH_MAC: begin
        if (mac_length == 8'd0) begin
          mac_length_next = stage_byte;
          mac_count_next  = 8'd0;
        end else if (mac_count < mac_length) begin
          res_valid      = 1'b1;
          res.kind       = unfd_pkg::KIND_MAC;
          res.data       = stage_byte;
          res.mac_index  = mac_count;
          mac_count_next = mac_count + 8'd1;
        end else begin
          // trailing byte swallowed
          mac_length_next = 8'd0;
          mac_count_next  = 8'd0;
          phase_next      = unfd_pkg::PH_HUNT;
        end
      end
      unfd_pkg::PH_PLEN: begin
        payload_length_next    = len_asm;
        length_bytes_read_next = length_bytes_read + LBR_W'(1);
        if (length_bytes_read == LBR_W'(LENGTH_FIELD_BYTES - 1)) begin
          if (len_asm == '0) begin
            length_bytes_read_next = '0;
            payload_length_next    = '0;
            payload_count_next     = '0;
            phase_next             = unfd_pkg::PH_HUNT;
          end else begin
            phase_next = unfd_pkg::PH_PAYLOAD;
          end
        end
      end
      unfd_pkg::PH_PAYLOAD: begin
        payload_count_next = count_inc;
        if (at_last) begin
          length_bytes_read_next = '0;
          payload_length_next    = '0;
          payload_count_next     = '0;
          phase_next             = unfd_pkg::PH_HUNT;
        end
        if (oversize) begin
          if (at_last) begin
            res_valid = 1'b1;
            res.kind  = unfd_pkg::KIND_DROP;
            res.last  = 1'b1;
          end
        end else begin
          res_valid = 1'b1;
          res.kind  = unfd_pkg::KIND_PAYLOAD;
          res.data  = stage_byte;
          res.last  = at_last;
        end
      end
      default: begin
        phase_next        = unfd_pkg::PH_HUNT;
        sync_matched_next = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= unfd_pkg::PH_HUNT;
      sync_matched      <= 2'd0;
      mac_length        <= 8'd0;
      mac_count         <= 8'd0;
      length_bytes_read <= '0;
      payload_length    <= '0;
      payload_count     <= '0;
    end else if (step) begin
      phase             <= phase_next;
      sync_matched      <= sync_matched_next;
      mac_length        <= mac_length_next;
      mac_count         <= mac_count_next;
      length_bytes_read <= length_bytes_read_next;
      payload_length    <= payload_length_next;
      payload_count     <= payload_count_next;
    end
  end

endmodule

// ===== hw/rtl/unfd_out_stage.sv =====
// Result register driving the output channel.
`timescale 1ns / 1ps

module unfd_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  unfd_pkg::res_t res,
  output logic           free,
  output logic           out_valid,
  input  logic           out_ready,
  output unfd_pkg::res_t out_res
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the serial frame deframer: directed frames, then random traffic.
`timescale 1ns / 1ps

module tb;

  localparam int LEN_BYTES       = 4;        // width of the packet length field
  localparam int DIR_ROWS        = 26;
  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 120;      // counted beats per random phase; the table comes on top
  localparam int DRAIN_CYCLES    = 4;        // pipeline is two deep, so this is plenty
  localparam int CYCLE_LIMIT     = 600000;

  localparam unfd_pkg::res_t NO_RES = '0;

  // One row of the directed table. Where typed is set, want is the result
  // written out by hand; otherwise the parser model works it out.
  typedef struct packed {
    logic [7:0]     b;
    logic           typed;
    unfd_pkg::res_t want;
  } row_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte     = 8'h00;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic [7:0]  mac_index;
  logic        last_of_packet;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  // Receiver behaviour: random stall rate plus a long hold-off when asked
  logic        rx_hold     = 1'b0;
  int unsigned rx_stall_pct = 0;
  // Sender behaviour: only touched by the stimulus process
  int unsigned tx_idle_pct = 0;

  int unsigned cycles_run = 0;
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;

  // Results the parser model says are owed, oldest first
  unfd_pkg::res_t pending_results[$];

  // Parser model state, mirrors the block's registers
  unfd_pkg::phase_t prs_phase = unfd_pkg::PH_HUNT;
  logic [1:0]  prs_sync    = '0;
  logic [7:0]  prs_mac_len = '0;
  logic [7:0]  prs_mac_cnt = '0;
  logic [2:0]  prs_len_rd  = '0;
  logic [31:0] prs_pkt_len = '0;
  logic [31:0] prs_pkt_cnt = '0;
  logic [15:0] prs_max_len = unfd_pkg::MAX_LEN_RESET;

  // Directed frames: broken sync, unknown type, link, empty packet, MAC with a
  // zero length byte that must be skipped.
  row_t dir_rows [DIR_ROWS] = '{
    '{unfd_pkg::SYNC_U, 1'b0, NO_RES},
    '{unfd_pkg::SYNC_U, 1'b0, NO_RES},                // breaks the match, not retried
    '{unfd_pkg::SYNC_N, 1'b0, NO_RES},
    '{unfd_pkg::SYNC_U, 1'b0, NO_RES},
    '{unfd_pkg::SYNC_N, 1'b0, NO_RES},
    '{unfd_pkg::SYNC_U, 1'b0, NO_RES},
    // stays in type state
    '{8'h02,  1'b1, '{unfd_pkg::KIND_UNKNOWN, 8'h02, 8'h00, 1'b0}},
    '{unfd_pkg::TYPE_LINK, 1'b0, NO_RES},
    '{8'hFF,  1'b1, '{unfd_pkg::KIND_LINK, 8'h01, 8'h00, 1'b0}},
    '{unfd_pkg::SYNC_U, 1'b0, NO_RES},
    '{unfd_pkg::SYNC_N, 1'b0, NO_RES},
    '{unfd_pkg::SYNC_U, 1'b0, NO_RES},
    '{unfd_pkg::TYPE_PACKET, 1'b0, NO_RES},
    '{8'h00,  1'b0, NO_RES},                          // zero length, nothing out
    '{8'h00,  1'b0, NO_RES},
    '{8'h00,  1'b0, NO_RES},
    '{8'h00,  1'b0, NO_RES},
    '{unfd_pkg::SYNC_U, 1'b0, NO_RES},
    '{unfd_pkg::SYNC_N, 1'b0, NO_RES},
    '{unfd_pkg::SYNC_U, 1'b0, NO_RES},
    '{unfd_pkg::TYPE_MAC, 1'b0, NO_RES},
    '{8'h00,  1'b0, NO_RES},                          // MAC length zero: wait again
    '{8'h02,  1'b0, NO_RES},
    '{8'h00,  1'b0, NO_RES},
    '{8'hFF,  1'b1, '{unfd_pkg::KIND_MAC, 8'hFF, 8'h01, 1'b0}},
    '{8'h80,  1'b0, NO_RES}                           // trailing byte swallowed
  };

  uart_nic_frame_deframer #(
    .LENGTH_FIELD_BYTES(LEN_BYTES)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .mac_index      (mac_index),
    .last_of_packet (last_of_packet),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parser model: advances on one received byte, returns 1 with the result
  // when the byte produces one.
  function automatic bit parse_byte(input logic [7:0] b, output unfd_pkg::res_t r);
    bit hit;
    hit = 1'b0;
    r   = NO_RES;
    case (prs_phase)
      unfd_pkg::PH_HUNT: begin
        // pattern is U,N,U; a mismatch clears the count and is not retried
        if (b == ((prs_sync == 2'd1) ? unfd_pkg::SYNC_N : unfd_pkg::SYNC_U)) begin
          if (prs_sync == unfd_pkg::SYNC_LAST) begin
            prs_sync  = '0;
            prs_phase = unfd_pkg::PH_TYPE;
          end else begin
            prs_sync = prs_sync + 2'd1;
          end
        end else begin
          prs_sync = '0;
        end
      end
      unfd_pkg::PH_TYPE: begin
        if (b == unfd_pkg::TYPE_MAC) begin
          prs_phase = unfd_pkg::PH_MAC;
        end else if (b == unfd_pkg::TYPE_LINK) begin
          prs_phase = unfd_pkg::PH_LINK;
        end else if (b == unfd_pkg::TYPE_PACKET) begin
          prs_phase   = unfd_pkg::PH_PLEN;
          prs_len_rd  = '0;
          prs_pkt_len = '0;
          prs_pkt_cnt = '0;
        end else begin
          hit    = 1'b1;
          r.kind = unfd_pkg::KIND_UNKNOWN;
          r.data = b;
        end
      end
      unfd_pkg::PH_LINK: begin
        prs_phase = unfd_pkg::PH_HUNT;
        hit       = 1'b1;
        r.kind    = unfd_pkg::KIND_LINK;
        r.data    = (b != 8'h00) ? 8'h01 : 8'h00;
      end
      unfd_pkg::PH_MAC: begin
        if (prs_mac_len == 8'h00) begin
          prs_mac_len = b;
          prs_mac_cnt = '0;
        end else if (prs_mac_cnt < prs_mac_len) begin
          hit         = 1'b1;
          r.kind      = unfd_pkg::KIND_MAC;
          r.data      = b;
          r.mac_index = prs_mac_cnt;
          prs_mac_cnt = prs_mac_cnt + 8'd1;
        end else begin
          prs_mac_len = '0;
          prs_mac_cnt = '0;
          prs_phase   = unfd_pkg::PH_HUNT;
        end
      end
      unfd_pkg::PH_PLEN: begin
        if (prs_len_rd < LEN_BYTES)
          prs_pkt_len = prs_pkt_len | (32'(b) << (8 * prs_len_rd));
        prs_len_rd = prs_len_rd + 3'd1;
        if (prs_len_rd >= LEN_BYTES) begin
          if (prs_pkt_len == 32'd0) begin
            prs_len_rd = '0;
            prs_phase  = unfd_pkg::PH_HUNT;
          end else begin
            prs_phase = unfd_pkg::PH_PAYLOAD;
          end
        end
      end
      unfd_pkg::PH_PAYLOAD: begin
        prs_pkt_cnt = prs_pkt_cnt + 32'd1;
        if (prs_pkt_len > 32'(prs_max_len)) begin
          // oversize: swallow quietly, flag once on the final byte
          if (prs_pkt_cnt == prs_pkt_len) begin
            hit    = 1'b1;
            r.kind = unfd_pkg::KIND_DROP;
            r.last = 1'b1;
          end
        end else begin
          hit    = 1'b1;
          r.kind = unfd_pkg::KIND_PAYLOAD;
          r.data = b;
          r.last = (prs_pkt_cnt == prs_pkt_len);
        end
        if (prs_pkt_cnt == prs_pkt_len) begin
          prs_len_rd  = '0;
          prs_pkt_len = '0;
          prs_pkt_cnt = '0;
          prs_phase   = unfd_pkg::PH_HUNT;
        end
      end
      default: begin
        prs_phase = unfd_pkg::PH_HUNT;
        prs_sync  = '0;
      end
    endcase
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("cycle %0d: %s: got %0d, want %0d", cycles_run, what, got, want);
  endtask

  // Offer one beat and return at the edge where it is taken. in_ready is
  // looked at on the falling edge, where it has settled.
  task automatic offer_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
    unfd_pkg::res_t r;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    offer_byte(b);
    if (parse_byte(b, r)) pending_results.push_back(r);
    if (counted) beats_sent++;
  endtask

  // Sender stops until every owed result is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_len(input logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    prs_max_len = v;
  endtask

  task automatic send_sync();
    send_byte(unfd_pkg::SYNC_U);
    send_byte(unfd_pkg::SYNC_N);
    send_byte(unfd_pkg::SYNC_U);
  endtask

  task automatic send_link();
    send_sync();
    send_byte(unfd_pkg::TYPE_LINK);
    send_byte(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255, 1)));
  endtask

  task automatic send_mac(input int unsigned len);
    send_sync();
    send_byte(unfd_pkg::TYPE_MAC);
    if ($urandom_range(3) == 0) send_byte(8'h00);     // zero length is skipped
    send_byte(8'(len));
    for (int i = 0; i < len; i++) send_byte(8'($urandom));
    send_byte(8'($urandom));                          // trailing byte
  endtask

  task automatic send_packet(input int unsigned len);
    send_sync();
    send_byte(unfd_pkg::TYPE_PACKET);
    for (int i = 0; i < LEN_BYTES; i++) send_byte(8'(len >> (8 * i)));
    for (int i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // A run of unknown type codes, then a link message to get back to hunting
  task automatic send_unknown();
    logic [7:0] code;
    send_sync();
    repeat ($urandom_range(3, 1)) begin
      do code = 8'($urandom);
      while (code == unfd_pkg::TYPE_MAC || code == unfd_pkg::TYPE_LINK ||
             code == unfd_pkg::TYPE_PACKET);
      send_byte(code);
    end
    send_byte(unfd_pkg::TYPE_LINK);
    send_byte(8'($urandom));
  endtask

  // Line noise and broken sync; always leaves the hunt with no partial match
  task automatic send_noise();
    logic [7:0] b;
    case ($urandom_range(2))
      0: begin
        repeat ($urandom_range(4, 1)) begin
          do b = 8'($urandom); while (b == unfd_pkg::SYNC_U);
          send_byte(b, 1'b0);
        end
      end
      1: begin
        send_byte(unfd_pkg::SYNC_U, 1'b0);
        do b = 8'($urandom); while (b == unfd_pkg::SYNC_N);  // may be U: dropped
        send_byte(b, 1'b0);
      end
      default: begin
        send_byte(unfd_pkg::SYNC_U, 1'b0);
        send_byte(unfd_pkg::SYNC_N, 1'b0);
        do b = 8'($urandom); while (b == unfd_pkg::SYNC_U);
        send_byte(b, 1'b0);
      end
    endcase
  endtask

  // Mostly short packets; some sit on the size limit either side, a few are long
  function automatic int unsigned pick_packet_len();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return 0;
    if (sel < 25 && prs_max_len <= 16'd600) return prs_max_len + $urandom_range(1);
    if (sel < 28) return $urandom_range(600, 256);
    return $urandom_range(40, 1);
  endfunction

  // Receiver: random stalls, or held off entirely while rx_hold is up
  always @(posedge clk) begin
    if (rst || rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Result checker: every beat taken goes against the oldest owed result
  always @(posedge clk) begin
    unfd_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with none owed, kind", out_kind, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_kind != want.kind) report_mismatch("out_kind", out_kind, want.kind);
        if (out_byte != want.data) report_mismatch("out_byte", out_byte, want.data);
        if (mac_index != want.mac_index)
          report_mismatch("mac_index", mac_index, want.mac_index);
        if (last_of_packet != want.last)
          report_mismatch("last_of_packet", last_of_packet, want.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    unfd_pkg::res_t r;
    bit          got_one;
    bit          paused;
    int unsigned phase_start;
    int unsigned mode;
    int unsigned pick;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table, no idling
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_byte(dir_rows[i].b);
      got_one = parse_byte(dir_rows[i].b, r);
      if (dir_rows[i].typed) pending_results.push_back(dir_rows[i].want);
      else if (got_one) pending_results.push_back(r);
    end

    // Random traffic in phases; each phase sets the size limit and the idling
    // pattern. Phase 0 keeps the reset limit.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: set_max_len(16'hFFFF);
        2: set_max_len(16'd1);
        3: set_max_len(16'd0);                        // every non-empty packet oversize
        4: set_max_len(16'($urandom_range(64, 2)));
        5: set_max_len(16'($urandom_range(300, 16)));
        6: set_max_len(unfd_pkg::MAX_LEN_RESET);
        7: set_max_len(16'($urandom_range(40, 1)));
        default: ;
      endcase

      // 0: none, 1: sender idles, 2: receiver stalls, 3: both, lightly
      mode         = ph % 4;
      tx_idle_pct  = (mode == 1) ? 88 : (mode == 3) ? 19 : 0;
      rx_stall_pct <= (mode == 2) ? 88 : (mode == 3) ? 19 : 0;

      phase_start = beats_sent;
      paused      = 1'b0;

      if (ph == 0) begin
        // long receiver hold-off while the sender keeps pushing: fills the pipe
        fork
          begin
            rx_hold <= 1'b1;
            repeat (300) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
        send_mac(255);                                // largest MAC index
      end

      while (beats_sent - phase_start < BEATS_PER_PHASE) begin
        if (ph == 4 && !paused && beats_sent - phase_start > BEATS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 15) send_link();
        else if (pick < 35) send_mac(($urandom_range(99) < 3) ? 255 : $urandom_range(8, 1));
        else if (pick < 80) send_packet(pick_packet_len());
        else if (pick < 90) send_unknown();
        else send_noise();
      end
    end

    drain();
    repeat (8) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch("results still owed at end", pending_results.size(), 0);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
